/* design/imucal_pkg.sv */
// imucal_pkg: shared constants, state encoding and divider interface types
// for the imu frame calibration averager; no dependencies

package imucal_pkg;

  // frame layout
  localparam int FRAME_BYTES = 20;
  localparam int IDX_W       = 5;
  localparam int NUM_CH      = 9;
  localparam int CH_W        = 4;
  localparam int WORD_W      = 16;
  localparam int SUM_W       = 24;

  localparam logic [7:0]      SYNC_BYTE      = 8'hFF;
  localparam logic [7:0]      TRAILER_BYTE   = 8'hFE;
  localparam logic [7:0]      MAXF_RESET     = 8'd10;
  localparam logic [CH_W-1:0] LAST_CH        = CH_W'(NUM_CH - 1);
  localparam logic [CH_W-1:0] FIRST_ACC_CH   = CH_W'(3);
  localparam logic [CH_W-1:0] FIRST_GYRO_CH  = CH_W'(6);

  // fixed point scaling
  localparam int FRAC_W  = 16;
  localparam int NUM_W   = 46;   // rounded dividend magnitude
  localparam int DEN_W   = 19;   // largest divisor is 1300 * 255
  localparam int QUO_W   = 32;

  localparam int ACC_BIAS = 300;
  localparam int ACC_GAIN = 49;
  localparam int ACC_DEN  = 1300;
  localparam int GYRO_DEN = 100;

  localparam logic [QUO_W-1:0] ANGLE_OFS = QUO_W'(180 * 65536);
  localparam logic [QUO_W-1:0] GYRO_OFS  = QUO_W'(300 * 65536);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_FIN_RD,
    ST_FIN_PREP,
    ST_FIN_DIV,
    ST_FIN_OUT,
    ST_NR_OUT
  } state_t;

  // divider request and status
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

/* design/imucal_div.sv */
// imucal_div: radix-2 restoring divider, one quotient bit per cycle
// depends on imucal_pkg for widths and the request/status structs

module imucal_div (
  input  logic                clk,
  input  logic                rst_n,
  input  imucal_pkg::div_req_t req,
  output imucal_pkg::div_rsp_t rsp
);
  import imucal_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] dvd_r, dvd_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             qbit;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem_r, dvd_r[NUM_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    qbit    = ~diff[DEN_W+1];
  end

  // iteration control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      dvd_nxt  = req.num;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      dvd_nxt = {dvd_r[NUM_W-2:0], qbit};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = dvd_r[QUO_W-1:0];

endmodule

/* design/imu_frame_calibration_averager_unit.sv */
// imu_frame_calibration_averager_unit: serial frame parser, sum memory and
// finish sequencer producing nine calibrated q16.16 averages
// depends on imucal_pkg and imucal_div
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  cfg     | cfg_wr_en, cfg_wr_data (max_frames)        | in
//  in      | in_valid, in_stall, in_action, in_data_byte | in
//  out     | out_valid, out_stall, out_channel,          | out
//          | out_average_value, out_responding, out_last |
//
// a serial byte is taken while in ST_IDLE; the byte that closes a good frame
// stalls the input for the read-modify-write of the nine sums, each read in
// ST_ACC_RD and written in ST_ACC_WR; finish runs the 46-step divider per
// channel for nine results, or gives one not-responding result if nothing was taken
// reset (rst_n low, synchronous) empties the parser, count and sums and
// sets max_frames to 10; out_stall holds the output register while the
// input side keeps taking bytes

module imu_frame_calibration_averager_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [7:0]                          cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic [7:0]                          in_data_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [imucal_pkg::CH_W-1:0]         out_channel,
  output logic signed [imucal_pkg::QUO_W-1:0] out_average_value,
  output logic                                out_responding,
  output logic                                out_last
);
  import imucal_pkg::*;

  state_t state_r, state_nxt;

  logic [7:0]        max_frames_r, max_frames_nxt;
  logic              sync_seen_r, sync_seen_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic [IDX_W-1:0]  byte_idx_r, byte_idx_nxt;
  logic [7:0]        lo_byte_r, lo_byte_nxt;
  logic [7:0]        valid_frames_r, valid_frames_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [NUM_CH-1:0] sum_vld_r, sum_vld_nxt;
  logic              neg_r, neg_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]   out_channel_r, out_channel_nxt;
  logic [QUO_W-1:0]  out_average_value_r, out_average_value_nxt;
  logic              out_responding_r, out_responding_nxt;
  logic              out_last_r, out_last_nxt;

  // word buffer and sum memory
  logic [WORD_W-1:0] wbuf_mem [NUM_CH];
  logic [SUM_W-1:0]  sum_mem [NUM_CH];
  logic [WORD_W-1:0] wbuf_q;
  logic [SUM_W-1:0]  sum_q;
  logic              sum_vld_q;
  logic              wbuf_we;
  logic [CH_W-1:0]   wbuf_waddr;
  logic [WORD_W-1:0] wbuf_wdata;
  logic              sum_we;
  logic [SUM_W-1:0]  sum_wdata;

  logic              in_xact;
  logic              out_free;
  logic [SUM_W-1:0]  sum_rd;

  // finish arithmetic
  logic [SUM_W:0]    bias;
  logic [SUM_W:0]    diff;
  logic [SUM_W:0]    diff_neg;
  logic              diff_sign;
  logic [SUM_W-1:0]  absd;
  logic [SUM_W+5:0]  acc_scaled;
  logic [NUM_W-1:0]  mag;
  logic [DEN_W-1:0]  den;
  logic [QUO_W-1:0]  sq;
  logic [QUO_W-1:0]  result;

  div_req_t div_req;
  div_rsp_t div_rsp;

  imucal_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_xact  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign sum_rd   = sum_vld_q ? sum_q : '0;

  // dividend and divisor for the channel just read
  always_comb begin
    bias       = (SUM_W+1)'(valid_frames_r) * (SUM_W+1)'(ACC_BIAS);
    diff       = {1'b0, sum_rd} - bias;
    diff_neg   = -diff;
    diff_sign  = diff[SUM_W];
    absd       = diff_sign ? diff_neg[SUM_W-1:0] : diff[SUM_W-1:0];
    acc_scaled = (SUM_W+6)'(absd) * (SUM_W+6)'(ACC_GAIN);
    if (ch_r < FIRST_ACC_CH) begin
      mag = NUM_W'({sum_rd, {(FRAC_W-1){1'b0}}});
      den = DEN_W'(valid_frames_r);
    end else if (ch_r < FIRST_GYRO_CH) begin
      mag = NUM_W'({acc_scaled, {FRAC_W{1'b0}}});
      den = DEN_W'(valid_frames_r) * DEN_W'(ACC_DEN);
    end else begin
      mag = NUM_W'({sum_rd, {FRAC_W{1'b0}}});
      den = DEN_W'(valid_frames_r) * DEN_W'(GYRO_DEN);
    end
    div_req.num = mag + NUM_W'(den >> 1);
    div_req.den = den;
  end

  // signed quotient and channel offset
  always_comb begin
    sq = neg_r ? -div_rsp.quo : div_rsp.quo;
    if (ch_r < FIRST_ACC_CH) begin
      result = sq - ANGLE_OFS;
    end else if (ch_r < FIRST_GYRO_CH) begin
      result = sq;
    end else begin
      result = sq - GYRO_OFS;
    end
  end

  // sequencer: next state, memory writes and output loads
  always_comb begin
    state_nxt             = state_r;
    max_frames_nxt        = cfg_wr_en ? cfg_wr_data : max_frames_r;
    sync_seen_nxt         = sync_seen_r;
    in_frame_nxt          = in_frame_r;
    byte_idx_nxt          = byte_idx_r;
    lo_byte_nxt           = lo_byte_r;
    valid_frames_nxt      = valid_frames_r;
    ch_nxt                = ch_r;
    sum_vld_nxt           = sum_vld_r;
    neg_nxt               = neg_r;
    out_valid_nxt         = out_valid_r && out_stall;
    out_channel_nxt       = out_channel_r;
    out_average_value_nxt = out_average_value_r;
    out_responding_nxt    = out_responding_r;
    out_last_nxt          = out_last_r;
    wbuf_we               = 1'b0;
    wbuf_waddr            = byte_idx_r[IDX_W-1:1];
    wbuf_wdata            = {in_data_byte, lo_byte_r};
    sum_we                = 1'b0;
    sum_wdata             = sum_rd + SUM_W'(wbuf_q);
    div_req.start         = 1'b0;
    in_stall              = (state_r != ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_xact) begin
          if (in_action) begin
            // finish: drop the parser, then report
            sync_seen_nxt = 1'b0;
            in_frame_nxt  = 1'b0;
            byte_idx_nxt  = '0;
            ch_nxt        = '0;
            state_nxt     = (valid_frames_r == '0) ? ST_NR_OUT : ST_FIN_RD;
          end else if (in_frame_r) begin
            if (byte_idx_r == IDX_W'(FRAME_BYTES - 1)) begin
              // closing byte: trailer check and frame limit
              in_frame_nxt = 1'b0;
              byte_idx_nxt = '0;
              if (lo_byte_r == TRAILER_BYTE && in_data_byte == TRAILER_BYTE &&
                  valid_frames_r < max_frames_r) begin
                ch_nxt    = '0;
                state_nxt = ST_ACC_RD;
              end
            end else begin
              byte_idx_nxt = byte_idx_r + IDX_W'(1);
              if (!byte_idx_r[0]) begin
                lo_byte_nxt = in_data_byte;
              end else begin
                wbuf_we = 1'b1;
              end
            end
          end else begin
            // sync hunt
            if (in_data_byte == SYNC_BYTE) begin
              if (sync_seen_r) begin
                sync_seen_nxt = 1'b0;
                in_frame_nxt  = 1'b1;
                byte_idx_nxt  = '0;
              end else begin
                sync_seen_nxt = 1'b1;
              end
            end else begin
              sync_seen_nxt = 1'b0;
            end
          end
        end
      end
      ST_ACC_RD: begin
        state_nxt = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        sum_we            = 1'b1;
        sum_vld_nxt[ch_r] = 1'b1;
        if (ch_r == LAST_CH) begin
          valid_frames_nxt = valid_frames_r + 8'd1;
          state_nxt        = ST_IDLE;
        end else begin
          ch_nxt    = ch_r + CH_W'(1);
          state_nxt = ST_ACC_RD;
        end
      end
      ST_FIN_RD: begin
        state_nxt = ST_FIN_PREP;
      end
      ST_FIN_PREP: begin
        div_req.start = 1'b1;
        neg_nxt       = (ch_r >= FIRST_ACC_CH) && (ch_r < FIRST_GYRO_CH) && diff_sign;
        state_nxt     = ST_FIN_DIV;
      end
      ST_FIN_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_FIN_OUT;
        end
      end
      ST_FIN_OUT: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_channel_nxt       = ch_r;
          out_average_value_nxt = result;
          out_responding_nxt    = 1'b1;
          out_last_nxt          = (ch_r == LAST_CH);
          if (ch_r == LAST_CH) begin
            valid_frames_nxt = '0;
            sum_vld_nxt      = '0;
            state_nxt        = ST_IDLE;
          end else begin
            ch_nxt    = ch_r + CH_W'(1);
            state_nxt = ST_FIN_RD;
          end
        end
      end
      ST_NR_OUT: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_channel_nxt       = '0;
          out_average_value_nxt = '0;
          out_responding_nxt    = 1'b0;
          out_last_nxt          = 1'b1;
          valid_frames_nxt      = '0;
          sum_vld_nxt           = '0;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      max_frames_r   <= MAXF_RESET;
      sync_seen_r    <= 1'b0;
      in_frame_r     <= 1'b0;
      byte_idx_r     <= '0;
      valid_frames_r <= '0;
      ch_r           <= '0;
      sum_vld_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      max_frames_r   <= max_frames_nxt;
      sync_seen_r    <= sync_seen_nxt;
      in_frame_r     <= in_frame_nxt;
      byte_idx_r     <= byte_idx_nxt;
      valid_frames_r <= valid_frames_nxt;
      ch_r           <= ch_nxt;
      sum_vld_r      <= sum_vld_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lo_byte_r           <= lo_byte_nxt;
    neg_r               <= neg_nxt;
    out_channel_r       <= out_channel_nxt;
    out_average_value_r <= out_average_value_nxt;
    out_responding_r    <= out_responding_nxt;
    out_last_r          <= out_last_nxt;
  end

  // frame word buffer, one write and one registered read
  always_ff @(posedge clk) begin
    if (wbuf_we) begin
      wbuf_mem[wbuf_waddr] <= wbuf_wdata;
    end
    wbuf_q <= wbuf_mem[ch_r];
  end

  // channel sum memory, registered read in ST_ACC_RD and ST_FIN_RD, write in ST_ACC_WR
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[ch_r] <= sum_wdata;
    end
    sum_q     <= sum_mem[ch_r];
    sum_vld_q <= sum_vld_r[ch_r];
  end

  assign out_valid         = out_valid_r;
  assign out_channel       = out_channel_r;
  assign out_average_value = out_average_value_r;
  assign out_responding    = out_responding_r;
  assign out_last          = out_last_r;

  // channel pointer stays inside the sum memory
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r <= LAST_CH)
    else $error("channel pointer out of range");

  // divider is never restarted mid-division
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // quotient arrives only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_FIN_DIV)
    else $error("unexpected divider completion");

  // accumulation only below the frame limit
  a_acc_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && state_nxt == ST_ACC_RD) |-> valid_frames_r < max_frames_r)
    else $error("frame accumulated beyond limit");

  // a not-responding transaction is a lone, zeroed, final result
  a_nr_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_responding_r) |->
      (out_last_r && out_channel_r == '0 && out_average_value_r == '0))
    else $error("malformed not-responding result");

endmodule
